/* rtl/lump_directory_name_lookup_unit_macros.svh */
// Assertion helpers used by the RTL of the name lookup unit.
`ifndef LUMP_DIRECTORY_NAME_LOOKUP_UNIT_MACROS_SVH
`define LUMP_DIRECTORY_NAME_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and held off while i_rst_n is low.
`define LDN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and held off while i_rst_n is low.
`define LDN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lump_dnl_pkg.sv */
package lump_dnl_pkg;

    localparam int unsigned ENTRIES_DEF = 1024;
    localparam int unsigned FILES_DEF   = 16;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned NAME_W     = 64;
    localparam int unsigned FILE_W     = 4;
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NAME_BYTES = NAME_W / BYTE_W;

    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 3'd0,
        OP_OPEN     = 3'd1,
        OP_APPEND   = 3'd2,
        OP_SRCH_NEW = 3'd3,
        OP_SRCH_OLD = 3'd4,
        OP_SRCH_ONE = 3'd5
    } t_op;

    // Per-cycle control handed to every byte cell of the chain.
    typedef struct packed {
        logic load;
        logic upper;
    } t_cell_ctl;

endpackage

/* rtl/lump_dnl_if.sv */
interface lump_dnl_in_if;
    import lump_dnl_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [NAME_W-1:0] entry_name;
    logic [FILE_W-1:0] target_file;
    logic [IDX_W-1:0]  start_index;

    modport source (output valid, output operation, output entry_name,
                    output target_file, output start_index, input ready);
    modport sink   (input valid, input operation, input entry_name,
                    input target_file, input start_index, output ready);
endinterface

interface lump_dnl_out_if;
    import lump_dnl_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [FILE_W-1:0] file_number;
    logic [IDX_W-1:0]  entry_index;
    logic              refused;

    modport source (output valid, output found, output file_number,
                    output entry_index, output refused, input ready);
    modport sink   (input valid, input found, input file_number,
                    input entry_index, input refused, output ready);
endinterface

/* rtl/lump_dnl_ram.sv */
module lump_dnl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/lump_dnl_cell.sv */
module lump_dnl_cell (
    input  logic                              i_clk,
    input  lump_dnl_pkg::t_cell_ctl           i_ctl,
    input  logic [lump_dnl_pkg::BYTE_W-1:0]   i_byte,
    input  logic                              i_ended,
    input  logic [lump_dnl_pkg::BYTE_W-1:0]   i_rd_byte,
    input  logic                              i_eq,
    output logic [lump_dnl_pkg::BYTE_W-1:0]   o_clean,
    output logic                              o_ended,
    output logic                              o_eq
);
    import lump_dnl_pkg::*;

    logic [BYTE_W-1:0] r_key;
    logic [BYTE_W-1:0] w_zeroed;

    // A byte after the terminator reads as zero; queries also fold a-z to A-Z.
    always_comb begin
        w_zeroed = i_ended ? '0 : i_byte;
        if (i_ctl.upper && (w_zeroed >= CHAR_LOWER_A) && (w_zeroed <= CHAR_LOWER_Z)) begin
            o_clean = w_zeroed - CASE_OFFSET;
        end else begin
            o_clean = w_zeroed;
        end
    end

    assign o_ended = i_ended || (i_byte == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= o_clean;
        end
    end

    assign o_eq = i_eq && (r_key == i_rd_byte);
endmodule

/* rtl/lump_directory_name_lookup_unit.sv */
// Name directory lookup unit: a priority CAM over 8-byte names kept in files.
//
// i_req carries one command per beat (clear, open file, append name, or one
// of three searches); o_rsp returns exactly one result beat for each command.
// Both channels use valid/ready; a beat moves when both are high.
//
// Clear, open and append finish in the cycle they are accepted, and their
// result is valid on o_rsp in the next cycle. A search walks every stored
// entry (up to ENTRIES) in ascending order through a single read port of the
// name memory, one entry per cycle, then passes through the drain and finish
// states before its result is registered; with an empty store it goes
// straight to the finish state. The query key sits in a row of eight byte
// cells that normalize it on load and compare it against the word read from
// memory, each cell passing the running match to its neighbor.
//
// One command is in flight at a time. The unit takes a new beat when it is
// idle and the output register is empty or being emptied in that cycle, so a
// stalled receiver holds the result in place and only blocks further input.
// Reset empties the directory (no files, no entries) and the output register;
// it needs no memory clearing.
`include "lump_directory_name_lookup_unit_macros.svh"

module lump_directory_name_lookup_unit #(
    parameter int unsigned ENTRIES = lump_dnl_pkg::ENTRIES_DEF,
    parameter int unsigned FILES   = lump_dnl_pkg::FILES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lump_dnl_in_if.sink           i_req,
    lump_dnl_out_if.source        o_rsp
);
    import lump_dnl_pkg::*;

    localparam int unsigned AW  = $clog2(ENTRIES);
    localparam int unsigned ETW = $clog2(ENTRIES + 1);
    localparam int unsigned FW  = (FILES > 1) ? $clog2(FILES) : 1;
    localparam int unsigned FTW = $clog2(FILES + 1);
    localparam int unsigned CW  = (FW > FILE_W) ? FW : FILE_W;
    localparam int unsigned LW  = (AW > IDX_W) ? AW : IDX_W;
    localparam int unsigned RW  = NAME_W + FW;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    // Control state.
    t_state            r_state, n_state;
    logic [FTW-1:0]    r_file_total, n_file_total;
    logic [ETW-1:0]    r_entry_total, n_entry_total;
    logic [ETW-1:0]    r_cur_cnt, n_cur_cnt;
    logic [ETW-1:0]    r_addr, n_addr;
    logic              r_rd_vld;
    logic              r_rd_first;
    logic              r_best_found, n_best_found;
    logic              r_out_valid, n_out_valid;

    // Payload state.
    t_op               r_op;
    logic [FILE_W-1:0] r_target;
    logic [IDX_W-1:0]  r_start;
    logic [FW-1:0]     r_prev_owner;
    logic [AW-1:0]     r_local;
    logic [FW-1:0]     r_best_file, n_best_file;
    logic [AW-1:0]     r_best_idx, n_best_idx;
    logic              r_out_found, n_out_found;
    logic [FILE_W-1:0] r_out_file, n_out_file;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic              r_out_refused, n_out_refused;

    logic              w_accept;
    t_op               w_op;
    logic              w_is_search;
    t_cell_ctl         w_ctl;
    logic [NAME_BYTES:0] w_ended;
    logic [NAME_BYTES:0] w_eq;
    logic [NAME_W-1:0] w_clean;
    logic              w_we;
    logic [RW-1:0]     w_rd_data;
    logic [FW-1:0]     w_rd_owner;
    logic [AW-1:0]     w_local;
    logic              w_mode_ok;
    logic              w_hit;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_op        = t_op'(i_req.operation);
    assign w_is_search = (w_op == OP_SRCH_NEW) || (w_op == OP_SRCH_OLD) ||
                         (w_op == OP_SRCH_ONE);

    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);

    // Byte cell chain: terminator flag runs left to right during cleaning,
    // and the match flag runs the same way during the walk.
    assign w_ctl.load  = w_accept && w_is_search;
    assign w_ctl.upper = w_is_search;
    assign w_ended[0]  = 1'b0;
    assign w_eq[0]     = 1'b1;

    for (genvar g = 0; g < NAME_BYTES; g++) begin : g_cell
        lump_dnl_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_byte    (i_req.entry_name[g*BYTE_W +: BYTE_W]),
            .i_ended   (w_ended[g]),
            .i_rd_byte (w_rd_data[g*BYTE_W +: BYTE_W]),
            .i_eq      (w_eq[g]),
            .o_clean   (w_clean[g*BYTE_W +: BYTE_W]),
            .o_ended   (w_ended[g+1]),
            .o_eq      (w_eq[g+1])
        );
    end

    // Each memory word holds the cleaned name and the file that owns it.
    lump_dnl_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_entry_total[AW-1:0]),
        .i_wdata ({FW'(r_file_total - FTW'(1)), w_clean}),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rd_data)
    );

    // Files own contiguous runs, so the index within a file restarts at zero
    // whenever the owner changes from one entry to the next.
    assign w_rd_owner = w_rd_data[NAME_W +: FW];
    assign w_local    = (r_rd_first || (w_rd_owner != r_prev_owner)) ? '0
                        : r_local + AW'(1);

    always_comb begin
        unique case (r_op)
            // Owners rise along the walk, so a match in a new file supersedes.
            OP_SRCH_NEW: w_mode_ok = !r_best_found || (w_rd_owner != r_best_file);
            OP_SRCH_OLD: w_mode_ok = !r_best_found;
            OP_SRCH_ONE: w_mode_ok = !r_best_found &&
                                     (CW'(w_rd_owner) == CW'(r_target)) &&
                                     (LW'(w_local) >= LW'(r_start));
            default:     w_mode_ok = 1'b0;
        endcase
    end

    assign w_hit = r_rd_vld && w_eq[NAME_BYTES] && w_mode_ok;

    always_comb begin
        n_state       = r_state;
        n_file_total  = r_file_total;
        n_entry_total = r_entry_total;
        n_cur_cnt     = r_cur_cnt;
        n_addr        = r_addr;
        n_best_found  = r_best_found;
        n_best_file   = r_best_file;
        n_best_idx    = r_best_idx;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_found   = r_out_found;
        n_out_file    = r_out_file;
        n_out_idx     = r_out_idx;
        n_out_refused = r_out_refused;
        w_we          = 1'b0;

        if (w_hit) begin
            n_best_found = 1'b1;
            n_best_file  = w_rd_owner;
            n_best_idx   = w_local;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_found   = 1'b0;
                    n_out_file    = '0;
                    n_out_idx     = '0;
                    n_out_refused = 1'b0;
                    n_out_valid   = !w_is_search;
                    unique case (w_op)
                        OP_CLEAR: begin
                            n_file_total  = '0;
                            n_entry_total = '0;
                        end
                        OP_OPEN: begin
                            if (r_file_total == FTW'(FILES)) begin
                                n_out_refused = 1'b1;
                            end else begin
                                n_out_file   = FILE_W'(r_file_total);
                                n_file_total = r_file_total + FTW'(1);
                                n_cur_cnt    = '0;
                            end
                        end
                        OP_APPEND: begin
                            if ((r_file_total == '0) ||
                                (r_entry_total == ETW'(ENTRIES))) begin
                                n_out_refused = 1'b1;
                            end else begin
                                w_we          = 1'b1;
                                n_out_file    = FILE_W'(r_file_total - FTW'(1));
                                n_out_idx     = IDX_W'(r_cur_cnt);
                                n_entry_total = r_entry_total + ETW'(1);
                                n_cur_cnt     = r_cur_cnt + ETW'(1);
                            end
                        end
                        OP_SRCH_NEW, OP_SRCH_OLD, OP_SRCH_ONE: begin
                            n_addr       = '0;
                            n_best_found = 1'b0;
                            n_state      = (r_entry_total == '0) ? ST_FINISH : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + ETW'(1);
                if (r_addr == r_entry_total - ETW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                n_out_valid   = 1'b1;
                n_out_found   = r_best_found;
                n_out_file    = r_best_found ? FILE_W'(r_best_file) : '0;
                n_out_idx     = r_best_found ? IDX_W'(r_best_idx) : '0;
                n_out_refused = 1'b0;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_file_total  <= '0;
            r_entry_total <= '0;
            r_cur_cnt     <= '0;
            r_addr        <= '0;
            r_rd_vld      <= 1'b0;
            r_rd_first    <= 1'b0;
            r_best_found  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_file_total  <= n_file_total;
            r_entry_total <= n_entry_total;
            r_cur_cnt     <= n_cur_cnt;
            r_addr        <= n_addr;
            r_rd_vld      <= (r_state == ST_SCAN);
            r_rd_first    <= (r_state == ST_SCAN) && (r_addr == '0);
            r_best_found  <= n_best_found;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= w_op;
            r_target <= i_req.target_file;
            r_start  <= i_req.start_index;
        end
        if (r_rd_vld) begin
            r_prev_owner <= w_rd_owner;
            r_local      <= w_local;
        end
        r_best_file   <= n_best_file;
        r_best_idx    <= n_best_idx;
        r_out_found   <= n_out_found;
        r_out_file    <= n_out_file;
        r_out_idx     <= n_out_idx;
        r_out_refused <= n_out_refused;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.file_number = r_out_file;
    assign o_rsp.entry_index = r_out_idx;
    assign o_rsp.refused     = r_out_refused;

    `LDN_ASSERT_NOW(a_ready_only_idle, i_req.ready, (r_state == ST_IDLE),
        "input taken while a search is running")
    `LDN_ASSERT_NOW(a_counts_bounded, 1'b1,
        (r_entry_total <= ETW'(ENTRIES)) && (r_file_total <= FTW'(FILES)),
        "entry or file count beyond capacity")
    `LDN_ASSERT_NOW(a_found_not_refused, r_out_valid, !(r_out_found && r_out_refused),
        "result both found and refused")
    `LDN_ASSERT_NEXT(a_search_starts,
        w_accept && w_is_search && (r_entry_total != '0), (r_state == ST_SCAN),
        "search did not start walking the store")
    `LDN_ASSERT_NEXT(a_finish_delivers, (r_state == ST_FINISH), r_out_valid,
        "finished search left no result")
endmodule

/* verif/lump_directory_name_lookup_unit_test.sv */
`timescale 1ns / 1ps

module lump_directory_name_lookup_unit_test;
    import lump_dnl_pkg::*;

    // Sizes of the directory, taken from the defaults the unit is built with.
    localparam int unsigned NAME_SLOTS = ENTRIES_DEF;
    localparam int unsigned FILE_SLOTS = FILES_DEF;

    // Operation codes the unit leaves unused; they must change nothing.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = CHAR_LOWER_A - CASE_OFFSET;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = CHAR_LOWER_Z - CASE_OFFSET;

    // Characters that random names are built from. A small alphabet makes
    // repeated names likely, and it holds both cases and the characters
    // just outside the a-z range.
    localparam int unsigned       NAME_CHAR_COUNT = 12;
    localparam logic [12*8-1:0]   NAME_CHARS      = {"ABCZabcz`{0", 8'hFF};

    // An upper-case name with no zero byte, put in the last slot of the store.
    localparam logic [NAME_W-1:0] LAST_SLOT_NAME  = 64'h5A5A_5A5A_4C41_5354;

    localparam int unsigned RESET_CYCLES    = 12;
    localparam int unsigned RANDOM_ITEMS    = 580;
    localparam int unsigned RANDOM_DEPTH    = 48;
    localparam int unsigned PRESSURE_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned CYCLE_LIMIT     = 1000000;
    localparam int unsigned PRINT_LIMIT     = 50;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NAME_W-1:0] name;
        logic [FILE_W-1:0] target;
        logic [IDX_W-1:0]  start;
    } t_dir_cmd;

    typedef struct packed {
        logic              found;
        logic [FILE_W-1:0] file_no;
        logic [IDX_W-1:0]  index;
        logic              refused;
    } t_dir_result;

    // One row of the directed table. When fixed is set, want is the result
    // typed in by hand; otherwise the predictor supplies it.
    typedef struct packed {
        t_dir_cmd    cmd;
        logic        fixed;
        t_dir_result want;
    } t_dir_step;

    localparam t_dir_result NOTHING = '0;
    localparam t_dir_result REFUSAL = {1'b0, 4'd0, 10'd0, 1'b1};

    logic i_clk;
    logic i_rst_n;

    lump_dnl_in_if  req_if ();
    lump_dnl_out_if rsp_if ();

    lump_directory_name_lookup_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Period of 4 ns.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Shadow copy of the directory. Only entries below entry_count and files
    // below file_count are ever read.
    logic [NAME_W-1:0] dir_names [NAME_SLOTS];
    logic [FILE_W-1:0] dir_owner [NAME_SLOTS];
    int unsigned       file_base [FILE_SLOTS];
    int unsigned       file_count;
    int unsigned       entry_count;

    // Results owed by the unit, oldest first.
    t_dir_result pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    bit          pressure_go    = 1'b0;
    logic        rsp_hold       = 1'b0;

    function automatic t_dir_cmd command(input logic [OP_W-1:0] op,
                                         input logic [NAME_W-1:0] name,
                                         input logic [FILE_W-1:0] target,
                                         input logic [IDX_W-1:0] start);
        t_dir_cmd c;
        c.op     = op;
        c.name   = name;
        c.target = target;
        c.start  = start;
        return c;
    endfunction

    // Clears every byte after the first zero byte and, for a query, folds
    // a-z to upper case. Stored names keep their case.
    function automatic logic [NAME_W-1:0] scrub_name(input logic [NAME_W-1:0] raw,
                                                     input bit upper);
        logic [NAME_W-1:0] res;
        logic [BYTE_W-1:0] ch;
        bit                ended;
        res   = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++) begin
            ch = raw[b*BYTE_W +: BYTE_W];
            if (ended) begin
                ch = '0;
            end
            if (ch == '0) begin
                ended = 1'b1;
            end
            if (upper && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
                ch = ch - CASE_OFFSET;
            end
            res[b*BYTE_W +: BYTE_W] = ch;
        end
        return res;
    endfunction

    // One past the last entry of file f.
    function automatic int unsigned file_limit(input int unsigned f);
        if (f + 1 < file_count) begin
            return file_base[f + 1];
        end
        return entry_count;
    endfunction

    // First entry in [lo, hi) holding key, or hi when there is none.
    function automatic int unsigned find_name(input logic [NAME_W-1:0] key,
                                              input int unsigned lo,
                                              input int unsigned hi);
        for (int unsigned e = lo; e < hi && e < NAME_SLOTS; e++) begin
            if (dir_names[e] == key) begin
                return e;
            end
        end
        return hi;
    endfunction

    // Applies one command to the shadow directory and returns its result.
    function automatic t_dir_result predict_lookup(input t_dir_cmd c);
        t_dir_result       r;
        logic [NAME_W-1:0] key;
        int unsigned       f;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       e;
        r   = '0;
        key = scrub_name(c.name, 1'b1);
        case (c.op)
            OP_CLEAR: begin
                file_count  = 0;
                entry_count = 0;
            end
            OP_OPEN: begin
                if (file_count >= FILE_SLOTS) begin
                    r.refused = 1'b1;
                end else begin
                    file_base[file_count] = entry_count;
                    r.file_no             = file_count[FILE_W-1:0];
                    file_count++;
                end
            end
            OP_APPEND: begin
                if (file_count == 0 || entry_count >= NAME_SLOTS) begin
                    r.refused = 1'b1;
                end else begin
                    f                      = file_count - 1;
                    dir_names[entry_count] = scrub_name(c.name, 1'b0);
                    dir_owner[entry_count] = f[FILE_W-1:0];
                    e                      = entry_count - file_base[f];
                    r.file_no              = f[FILE_W-1:0];
                    r.index                = e[IDX_W-1:0];
                    entry_count++;
                end
            end
            OP_SRCH_NEW: begin
                // Newest file first; within a file the lowest index wins.
                for (f = file_count; f > 0 && !r.found; f--) begin
                    lo = file_base[f - 1];
                    hi = file_limit(f - 1);
                    e  = find_name(key, lo, hi);
                    if (e < hi) begin
                        r.found   = 1'b1;
                        lo        = f - 1;
                        r.file_no = lo[FILE_W-1:0];
                        e         = e - file_base[f - 1];
                        r.index   = e[IDX_W-1:0];
                    end
                end
            end
            OP_SRCH_OLD: begin
                e = find_name(key, 0, entry_count);
                if (e < entry_count) begin
                    f         = dir_owner[e];
                    r.found   = 1'b1;
                    r.file_no = f[FILE_W-1:0];
                    e         = e - file_base[f];
                    r.index   = e[IDX_W-1:0];
                end
            end
            OP_SRCH_ONE: begin
                // A missing file or a start past the file's end finds nothing.
                if (c.target < file_count) begin
                    lo = file_base[c.target];
                    hi = file_limit(c.target);
                    if (c.start < hi - lo) begin
                        e = find_name(key, lo + c.start, hi);
                        if (e < hi) begin
                            r.found   = 1'b1;
                            r.file_no = c.target;
                            e         = e - lo;
                            r.index   = e[IDX_W-1:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // A name of zero to eight characters from the small alphabet, with
    // random garbage after its terminator; now and then a fully random word.
    function automatic logic [NAME_W-1:0] random_name();
        logic [NAME_W-1:0] v;
        int unsigned       len;
        int unsigned       pick;
        v = {$urandom, $urandom};
        if ($urandom_range(9) == 0) begin
            return v;
        end
        len = $urandom_range(NAME_BYTES);
        for (int unsigned b = 0; b < len; b++) begin
            pick = $urandom_range(NAME_CHAR_COUNT - 1);
            v[b*BYTE_W +: BYTE_W] = NAME_CHARS[pick*BYTE_W +: BYTE_W];
        end
        if (len < NAME_BYTES) begin
            v[len*BYTE_W +: BYTE_W] = '0;
        end
        return v;
    endfunction

    // Builds the next random command from the current shadow state. The mix
    // keeps the directory small and mostly well formed: files get opened,
    // names appended (often repeated), and searches mostly ask for names
    // that are stored, with their case changed and garbage after the end.
    function automatic t_dir_cmd next_random_command();
        t_dir_cmd          c;
        logic [NAME_W-1:0] known;
        logic [BYTE_W-1:0] ch;
        int unsigned       pick;
        int unsigned       rnd;
        bit                ended;
        rnd      = $urandom;
        c.op     = OP_SRCH_NEW;
        c.name   = random_name();
        c.target = rnd[3:0];
        c.start  = rnd[13:4];
        pick     = $urandom_range(99);
        if (entry_count > RANDOM_DEPTH || pick < 2 ||
            (file_count == FILE_SLOTS && pick < 20)) begin
            c.op = OP_CLEAR;
        end else if (pick < 5) begin
            c.op = ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
        end else if (file_count == 0 || pick < 12) begin
            c.op = OP_OPEN;
        end else if (pick < 40) begin
            c.op = OP_APPEND;
            if (entry_count != 0 && $urandom_range(3) == 0) begin
                c.name = dir_names[$urandom_range(entry_count - 1)];
            end
        end else begin
            c.op = (pick < 60) ? OP_SRCH_NEW : (pick < 78) ? OP_SRCH_OLD : OP_SRCH_ONE;
            if (entry_count != 0 && $urandom_range(9) < 7) begin
                known = dir_names[$urandom_range(entry_count - 1)];
                ended = 1'b0;
                for (int b = 0; b < NAME_BYTES; b++) begin
                    ch  = known[b*BYTE_W +: BYTE_W];
                    rnd = $urandom;
                    if (ended) begin
                        ch = rnd[7:0];
                    end else if (ch == '0) begin
                        ended = 1'b1;
                    end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z && rnd[8]) begin
                        ch = ch + CASE_OFFSET;
                    end
                    known[b*BYTE_W +: BYTE_W] = ch;
                end
                c.name = known;
            end
            if (c.op == OP_SRCH_ONE && file_count != 0 && $urandom_range(3) != 0) begin
                rnd      = $urandom_range(file_count);
                c.target = rnd[3:0];
                rnd      = $urandom_range(5);
                c.start  = rnd[9:0];
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Offers one command beat, after a random gap, and holds it until taken.
    // valid is left high on return so back-to-back beats need no dip.
    task automatic push_command(input t_dir_cmd c, input logic fixed,
                                input t_dir_result want);
        t_dir_result predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= c.op;
        req_if.entry_name  <= c.name;
        req_if.target_file <= c.target;
        req_if.start_index <= c.start;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        predicted = predict_lookup(c);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // Result side: checks every accepted beat against the oldest expectation
    // and picks the next cycle's ready. A long hold-off overrides the stall.
    always @(posedge i_clk) begin : rsp_check
        t_dir_result got;
        t_dir_result want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.found, rsp_if.file_number, rsp_if.entry_index,
                       rsp_if.refused};
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with no command pending",
                                    64'(got), 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found) begin
                        report_mismatch("found", 64'(got.found), 64'(want.found));
                    end
                    if (got.file_no !== want.file_no) begin
                        report_mismatch("file_number", 64'(got.file_no),
                                        64'(want.file_no));
                    end
                    if (got.index !== want.index) begin
                        report_mismatch("entry_index", 64'(got.index), 64'(want.index));
                    end
                    if (got.refused !== want.refused) begin
                        report_mismatch("refused", 64'(got.refused), 64'(want.refused));
                    end
                end
            end
            rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off. The sender keeps offering beats meanwhile, so
    // the unit's output register fills and its input stalls.
    initial begin : rsp_pressure
        wait (pressure_go);
        rsp_hold <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_step         steps [$];
        t_dir_cmd          c;
        logic [NAME_W-1:0] nm;
        int unsigned       done;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.operation   = '0;
        req_if.entry_name  = '0;
        req_if.target_file = '0;
        req_if.start_index = '0;
        file_count         = 0;
        entry_count        = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. An empty directory first: searches miss, an append
        // with no file is refused, and the unused codes give all zeros.
        steps.push_back({command(OP_SRCH_NEW, 64'd0, 4'd0, 10'd0), 1'b1, NOTHING});
        steps.push_back({command(OP_APPEND, 64'h0041, 4'd0, 10'd0), 1'b1, REFUSAL});
        steps.push_back({command(OP_SPARE_A, '1, 4'hF, 10'h3FF), 1'b1, NOTHING});
        steps.push_back({command(OP_SPARE_B, '1, 4'hF, 10'h3FF), 1'b1, NOTHING});
        // File 0: a lower-case name, an all-ones word, a name with garbage
        // after its terminator, and the empty name.
        steps.push_back({command(OP_OPEN, 64'd0, 4'd0, 10'd0), 1'b1, NOTHING});
        steps.push_back({command(OP_APPEND, 64'h636261, 4'd0, 10'd0), 1'b1, NOTHING});
        steps.push_back({command(OP_APPEND, '1, 4'd0, 10'd0), 1'b1,
                         t_dir_result'({1'b0, 4'd0, 10'd1, 1'b0})});
        steps.push_back({command(OP_APPEND, 64'h1122_3344_5500_4241, 4'd0, 10'd0), 1'b1,
                         t_dir_result'({1'b0, 4'd0, 10'd2, 1'b0})});
        steps.push_back({command(OP_APPEND, 64'd0, 4'd0, 10'd0), 1'b1,
                         t_dir_result'({1'b0, 4'd0, 10'd3, 1'b0})});
        // File 1 holds the upper-case twin of the lower-case name in file 0.
        steps.push_back({command(OP_OPEN, 64'd0, 4'd0, 10'd0), 1'b1,
                         t_dir_result'({1'b0, 4'd1, 10'd0, 1'b0})});
        steps.push_back({command(OP_APPEND, 64'h434241, 4'd0, 10'd0), 1'b1,
                         t_dir_result'({1'b0, 4'd1, 10'd0, 1'b0})});
        // Searches: case folding of the query, garbage after the terminator,
        // the all-ones word, the empty name, and each search mode.
        steps.push_back({command(OP_SRCH_NEW, 64'h636261, 4'd0, 10'd0), 1'b0, NOTHING});
        steps.push_back({command(OP_SRCH_OLD, 64'h434241, 4'd0, 10'd0), 1'b0, NOTHING});
        steps.push_back({command(OP_SRCH_OLD, 64'hFFFF_FFFF_FF00_4241, 4'd0, 10'd0),
                         1'b0, NOTHING});
        steps.push_back({command(OP_SRCH_NEW, '1, 4'd0, 10'd0), 1'b0, NOTHING});
        steps.push_back({command(OP_SRCH_NEW, 64'd0, 4'd0, 10'd0), 1'b0, NOTHING});
        steps.push_back({command(OP_SRCH_ONE, 64'd0, 4'd0, 10'd3), 1'b0, NOTHING});
        // A start index just past the file, then missing files.
        steps.push_back({command(OP_SRCH_ONE, 64'd0, 4'd0, 10'd4), 1'b1, NOTHING});
        steps.push_back({command(OP_SRCH_ONE, '1, 4'hF, 10'h3FF), 1'b1, NOTHING});
        steps.push_back({command(OP_SRCH_ONE, 64'd0, 4'd2, 10'd0), 1'b1, NOTHING});
        steps.push_back({command(OP_SRCH_ONE, 64'h636261, 4'd1, 10'd0), 1'b0, NOTHING});
        // Characters on either side of a-z are not folded, so this misses.
        steps.push_back({command(OP_SRCH_NEW, 64'h7B7A60, 4'd0, 10'd0), 1'b1, NOTHING});
        // Clear empties everything; a new open starts again at file 0.
        steps.push_back({command(OP_CLEAR, '1, 4'hF, 10'h3FF), 1'b1, NOTHING});
        steps.push_back({command(OP_SRCH_OLD, 64'h434241, 4'd0, 10'd0), 1'b1, NOTHING});
        steps.push_back({command(OP_OPEN, 64'd0, 4'd0, 10'd0), 1'b1, NOTHING});
        foreach (steps[k]) begin
            push_command(steps[k].cmd, steps[k].fixed, steps[k].want);
        end

        // Full directory: one file takes every slot, so the append index
        // reaches its top value and the next append is refused. Opens still
        // succeed with the store full until the file table is full too.
        send_gap_pct   = 16;
        recv_stall_pct = 16;
        push_command(command(OP_CLEAR, 64'd0, 4'd0, 10'd0), 1'b0, NOTHING);
        push_command(command(OP_OPEN, 64'd0, 4'd0, 10'd0), 1'b0, NOTHING);
        for (int unsigned n = 0; n <= NAME_SLOTS; n++) begin
            if (n == NAME_SLOTS - 1) begin
                nm = LAST_SLOT_NAME;
            end else if (n != 0 && $urandom_range(4) == 0) begin
                nm = dir_names[$urandom_range(n - 1)];
            end else begin
                nm = random_name();
            end
            push_command(command(OP_APPEND, nm, 4'd0, 10'd0), 1'b0, NOTHING);
        end
        for (int unsigned n = 0; n < FILE_SLOTS; n++) begin
            push_command(command(OP_OPEN, 64'd0, 4'd0, 10'd0), 1'b0, NOTHING);
        end
        push_command(command(OP_APPEND, random_name(), 4'd0, 10'd0), 1'b0, NOTHING);
        push_command(command(OP_SRCH_NEW, LAST_SLOT_NAME, 4'd0, 10'd0), 1'b0, NOTHING);
        push_command(command(OP_SRCH_OLD, LAST_SLOT_NAME, 4'd0, 10'd0), 1'b0, NOTHING);
        push_command(command(OP_SRCH_ONE, LAST_SLOT_NAME, 4'd0, 10'h3FF), 1'b0, NOTHING);
        push_command(command(OP_SRCH_ONE, random_name(), 4'd0, 10'h3FF), 1'b0, NOTHING);
        push_command(command(OP_SRCH_ONE, dir_names[0], 4'd0, 10'd0), 1'b0, NOTHING);
        push_command(command(OP_SRCH_ONE, dir_names[0], 4'hF, 10'd0), 1'b0, NOTHING);
        push_command(command(OP_SRCH_NEW, random_name(), 4'd0, 10'd0), 1'b0, NOTHING);
        push_command(command(OP_SRCH_OLD, dir_names[$urandom_range(NAME_SLOTS - 1)],
                             4'd0, 10'd0), 1'b0, NOTHING);
        push_command(command(OP_CLEAR, 64'd0, 4'd0, 10'd0), 1'b0, NOTHING);

        // Random part in four flow-control settings. The first one also runs
        // the long receiver hold-off while the sender offers without gaps.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                    pressure_go    = 1'b1;
                end
                1: begin
                    send_gap_pct   = 73;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 73;
                end
                default: begin
                    send_gap_pct   = 16;
                    recv_stall_pct = 16;
                end
            endcase
            done = 0;
            while (done < RANDOM_ITEMS / 4) begin
                c = next_random_command();
                push_command(c, 1'b0, NOTHING);
                if (c.op != OP_SPARE_A && c.op != OP_SPARE_B) begin
                    done++;
                end
            end
        end

        // Drain. A result still owed here ends in the cycle limit.
        req_if.valid   <= 1'b0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
